// File: src/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// shared types, plane codes and plane selection tables for the frustum plane
// extraction block
// ----------------------------------------------------------------------------
package fpe_pkg;

   localparam int DATA_W      = 32;
   localparam int LANES       = 4;
   localparam int ROW_W       = DATA_W * LANES;
   localparam int PLANE_COUNT = 6;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [2:0]               plane_code_type;

   // plane codes
   localparam plane_code_type PLANE_LEFT   = 3'd0;
   localparam plane_code_type PLANE_RIGHT  = 3'd1;
   localparam plane_code_type PLANE_TOP    = 3'd2;
   localparam plane_code_type PLANE_BOTTOM = 3'd3;
   localparam plane_code_type PLANE_NEAR   = 3'd4;
   localparam plane_code_type PLANE_FAR    = 3'd5;

   localparam elem_type ELEM_MAX = 32'sh7fffffff;
   localparam elem_type ELEM_MIN = 32'sh80000000;

   // pick one lane of a row word
   function automatic elem_type row_lane(input row_type row, input logic [1:0] sel);
      row_lane = row[sel*DATA_W +: DATA_W];
   endfunction

   // column 4 takes part in every plane but near
   function automatic logic plane_uses_w(input plane_code_type p);
      plane_uses_w = (p != PLANE_NEAR);
   endfunction

   // second column of the plane (0 based)
   function automatic logic [1:0] plane_col(input plane_code_type p);
      case (p)
         PLANE_LEFT, PLANE_RIGHT:  plane_col = 2'd0;
         PLANE_TOP, PLANE_BOTTOM:  plane_col = 2'd1;
         default:                  plane_col = 2'd2;
      endcase
   endfunction

   // second column is subtracted
   function automatic logic plane_sub(input plane_code_type p);
      case (p)
         PLANE_RIGHT, PLANE_TOP, PLANE_FAR: plane_sub = 1'b1;
         default:                           plane_sub = 1'b0;
      endcase
   endfunction

endpackage

// File: src/frustum_plane_extract_top.sv
// ----------------------------------------------------------------------------
// frustum_plane_extract_top
// loads view and projection rows, forms their product and extracts the six
// normalized clip planes with one shared multiplier, root and divide unit
// ----------------------------------------------------------------------------
//  channel   direction  ports                                   words
//  req       in         req_valid/req_stall + row fields        one matrix row
//  rsp       out        rsp_valid/rsp_stall + plane fields      one plane
//
//  a row without go is only written to its store; a go word holds req_stall high
//  through the multiply-accumulate of the product and, per plane, the reads and
//  squares, 32 root steps, four divides and one emit, set by the single multiplier
//  and the bit-serial root and divide. reset clears all control state; the
//  matrix stores are not cleared. rsp_stall only delays the next plane's load.
// ----------------------------------------------------------------------------
module frustum_plane_extract_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_matrix_select,
   input  logic [1:0]  req_row_index,
   input  logic signed [31:0] req_elem0,
   input  logic signed [31:0] req_elem1,
   input  logic signed [31:0] req_elem2,
   input  logic signed [31:0] req_elem3,
   input  logic        req_go,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_plane_index,
   output logic signed [31:0] rsp_plane_a,
   output logic signed [31:0] rsp_plane_b,
   output logic signed [31:0] rsp_plane_c,
   output logic signed [31:0] rsp_plane_d,
   output logic        rsp_degenerate,
   output logic        rsp_last_plane
);

   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int DCW   = $clog2(NUM_W + 1);
   localparam int ACC_W = 66;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_PRD  = 4'd2;
   localparam logic [3:0] S_PCMP = 4'd3;
   localparam logic [3:0] S_SQ   = 4'd4;
   localparam logic [3:0] S_SQRT = 4'd5;
   localparam logic [3:0] S_DIVI = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;

   localparam logic signed [ACC_W-1:0] ACC_HALF =
      ACC_W'(1) <<< (FRAC_BITS - 1);

   logic [3:0] state_ff;

   // input handshake and row stores
   logic          req_accept;
   fpe_pkg::row_type req_row;
   fpe_pkg::row_type view_rdata, proj_rdata, mat_rdata;
   logic [1:0]    view_raddr, proj_raddr, mat_raddr;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_row    = {req_elem3, req_elem2, req_elem1, req_elem0};

   // product pipeline state
   logic [5:0]  cnt_ff;
   logic        issue_done_ff;
   logic        d1_ff, d2_ff, d3_ff;
   logic [5:0]  idx1_ff, idx2_ff, idx3_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   fpe_pkg::elem_type rowbuf_ff [fpe_pkg::LANES];
   logic        m_we_ff;
   logic [1:0]  m_waddr_ff;

   // plane state
   fpe_pkg::plane_code_type plane_ff;
   logic [1:0]  ci_ff, sqi_ff, di_ff;
   fpe_pkg::elem_type comp_ff [fpe_pkg::LANES];
   fpe_pkg::elem_type norm_ff [fpe_pkg::LANES];
   logic [63:0] sum_ff, n_ff, res_ff, bit_ff;
   logic [5:0]  step_ff;
   logic        degen_ff;
   logic [NUM_W-1:0] num_ff, quo_ff;
   logic [32:0] rem_ff;
   logic [DCW-1:0] dcnt_ff;
   logic        neg_ff;

   // output register
   logic        rsp_valid_ff;
   fpe_pkg::plane_code_type rsp_index_ff;
   fpe_pkg::elem_type rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;
   logic        rsp_degen_ff, rsp_last_ff;
   logic        rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   fpe_ram #(.WIDTH(fpe_pkg::ROW_W), .DEPTH(4)) u_view_ram (
      .clock (clock),
      .we    (req_accept && !req_matrix_select),
      .waddr (req_row_index),
      .wdata (req_row),
      .raddr (view_raddr),
      .rdata (view_rdata)
   );

   fpe_ram #(.WIDTH(fpe_pkg::ROW_W), .DEPTH(4)) u_proj_ram (
      .clock (clock),
      .we    (req_accept && req_matrix_select),
      .waddr (req_row_index),
      .wdata (req_row),
      .raddr (proj_raddr),
      .rdata (proj_rdata)
   );

   fpe_ram #(.WIDTH(fpe_pkg::ROW_W), .DEPTH(4)) u_mat_ram (
      .clock (clock),
      .we    (m_we_ff),
      .waddr (m_waddr_ff),
      .wdata ({rowbuf_ff[3], rowbuf_ff[2], rowbuf_ff[1], rowbuf_ff[0]}),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   // read addresses: view row i, projection row k, product row ci
   assign view_raddr = cnt_ff[5:4];
   assign proj_raddr = cnt_ff[1:0];
   assign mat_raddr  = ci_ff;

   // shared multiplier operands
   fpe_pkg::elem_type mul_a, mul_b;
   always_comb begin
      if (state_ff == S_SQ) begin
         mul_a = comp_ff[sqi_ff];
         mul_b = comp_ff[sqi_ff];
      end else begin
         mul_a = fpe_pkg::row_lane(view_rdata, idx1_ff[1:0]);
         mul_b = fpe_pkg::row_lane(proj_rdata, idx1_ff[3:2]);
      end
   end

   // accumulate with rounding half preloaded
   assign acc_in = ((idx2_ff[1:0] == 2'd0) ? ACC_HALF : acc_ff) + ACC_W'(prod_ff);

   // product element: shift and saturate
   logic signed [ACC_W-1:0] acc_sh;
   fpe_pkg::elem_type elem_sat;
   always_comb begin
      acc_sh = acc_ff >>> FRAC_BITS;
      if (acc_sh > ACC_W'(fpe_pkg::ELEM_MAX)) begin
         elem_sat = fpe_pkg::ELEM_MAX;
      end else if (acc_sh < ACC_W'(fpe_pkg::ELEM_MIN)) begin
         elem_sat = fpe_pkg::ELEM_MIN;
      end else begin
         elem_sat = acc_sh[31:0];
      end
   end

   // plane component from one product row
   fpe_pkg::elem_type col_w, col_x, comp_sat;
   logic signed [33:0] comp_sum;
   always_comb begin
      col_w = fpe_pkg::row_lane(mat_rdata, 2'd3);
      col_x = fpe_pkg::row_lane(mat_rdata, fpe_pkg::plane_col(plane_ff));
      comp_sum = fpe_pkg::plane_uses_w(plane_ff) ? 34'(col_w) : 34'sd0;
      if (fpe_pkg::plane_sub(plane_ff)) begin
         comp_sum = comp_sum - 34'(col_x);
      end else begin
         comp_sum = comp_sum + 34'(col_x);
      end
      if (comp_sum > 34'(fpe_pkg::ELEM_MAX)) begin
         comp_sat = fpe_pkg::ELEM_MAX;
      end else if (comp_sum < 34'(fpe_pkg::ELEM_MIN)) begin
         comp_sat = fpe_pkg::ELEM_MIN;
      end else begin
         comp_sat = comp_sum[31:0];
      end
   end

   // root step
   logic [63:0] sq_trial;
   assign sq_trial = res_ff + bit_ff;

   // divide setup and step
   fpe_pkg::elem_type div_x;
   logic        div_neg;
   logic [31:0] div_mag;
   logic [NUM_W-1:0] div_num;
   logic [32:0] rem_sh;
   logic        rem_ge;
   always_comb begin
      div_x   = comp_ff[di_ff];
      div_neg = div_x[31];
      div_mag = div_neg ? (32'd0 - div_x) : div_x;
      div_num = (NUM_W'(div_mag) << FRAC_BITS) + NUM_W'(res_ff[31:1]);
      rem_sh  = {rem_ff[31:0], num_ff[NUM_W-1]};
      rem_ge  = (rem_sh >= {1'b0, res_ff[31:0]});
   end

   // quotient to signed saturated result
   fpe_pkg::elem_type div_res;
   always_comb begin
      if (neg_ff) begin
         if (quo_ff >= NUM_W'(33'h080000000)) begin
            div_res = fpe_pkg::ELEM_MIN;
         end else begin
            div_res = 32'd0 - quo_ff[31:0];
         end
      end else begin
         if (quo_ff > NUM_W'(fpe_pkg::ELEM_MAX)) begin
            div_res = fpe_pkg::ELEM_MAX;
         end else begin
            div_res = quo_ff[31:0];
         end
      end
   end

   // free running shared multiplier
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         issue_done_ff <= 1'b0;
         d1_ff         <= 1'b0;
         d2_ff         <= 1'b0;
         d3_ff         <= 1'b0;
         m_we_ff       <= 1'b0;
         plane_ff      <= fpe_pkg::PLANE_LEFT;
         ci_ff         <= '0;
         sqi_ff        <= '0;
         di_ff         <= '0;
         step_ff       <= '0;
         dcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // product pipeline stages
         d1_ff   <= (state_ff == S_MUL) && !issue_done_ff;
         idx1_ff <= cnt_ff;
         d2_ff   <= d1_ff;
         idx2_ff <= idx1_ff;
         d3_ff   <= d2_ff;
         idx3_ff <= idx2_ff;
         if (d2_ff) begin
            acc_ff <= acc_in;
         end
         m_we_ff <= d3_ff && (idx3_ff[3:0] == 4'hf);
         if (d3_ff && idx3_ff[1:0] == 2'd3) begin
            rowbuf_ff[idx3_ff[3:2]] <= elem_sat;
            if (idx3_ff[3:2] == 2'd3) begin
               m_waddr_ff <= idx3_ff[5:4];
            end
         end

         // output word valid: set on emit, cleared once taken
         if (state_ff == S_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept && req_go) begin
                  state_ff      <= S_MUL;
                  cnt_ff        <= '0;
                  issue_done_ff <= 1'b0;
               end
            end
            S_MUL: begin
               if (!issue_done_ff) begin
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd63) begin
                     issue_done_ff <= 1'b1;
                  end
               end else if (!d1_ff && !d2_ff && !d3_ff && !m_we_ff) begin
                  state_ff <= S_PRD;
                  plane_ff <= fpe_pkg::PLANE_LEFT;
                  ci_ff    <= '0;
               end
            end
            S_PRD: begin
               state_ff <= S_PCMP;
            end
            S_PCMP: begin
               comp_ff[ci_ff] <= comp_sat;
               ci_ff          <= ci_ff + 2'd1;
               if (ci_ff == 2'd3) begin
                  state_ff <= S_SQ;
                  sqi_ff   <= '0;
                  sum_ff   <= '0;
               end else begin
                  state_ff <= S_PRD;
               end
            end
            S_SQ: begin
               sqi_ff <= sqi_ff + 2'd1;
               if (sqi_ff != 2'd0) begin
                  sum_ff <= sum_ff + prod_ff;
               end
               if (sqi_ff == 2'd3) begin
                  if (sum_ff + prod_ff == 64'd0) begin
                     degen_ff <= 1'b1;
                     for (int i = 0; i < fpe_pkg::LANES; i++) begin
                        norm_ff[i] <= '0;
                     end
                     state_ff <= S_EMIT;
                  end else begin
                     degen_ff <= 1'b0;
                     n_ff     <= sum_ff + prod_ff;
                     res_ff   <= '0;
                     bit_ff   <= 64'h4000000000000000;
                     step_ff  <= '0;
                     state_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (n_ff >= sq_trial) begin
                  n_ff   <= n_ff - sq_trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd31) begin
                  state_ff <= S_DIVI;
                  di_ff    <= '0;
               end
            end
            S_DIVI: begin
               num_ff   <= div_num;
               neg_ff   <= div_neg;
               rem_ff   <= '0;
               quo_ff   <= '0;
               dcnt_ff  <= DCW'(NUM_W);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (dcnt_ff != '0) begin
                  num_ff  <= num_ff << 1;
                  rem_ff  <= rem_ge ? (rem_sh - {1'b0, res_ff[31:0]}) : rem_sh;
                  quo_ff  <= {quo_ff[NUM_W-2:0], rem_ge};
                  dcnt_ff <= dcnt_ff - DCW'(1);
               end else begin
                  norm_ff[di_ff] <= div_res;
                  di_ff          <= di_ff + 2'd1;
                  state_ff       <= (di_ff == 2'd3) ? S_EMIT : S_DIVI;
               end
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_index_ff <= plane_ff;
                  rsp_a_ff     <= norm_ff[0];
                  rsp_b_ff     <= norm_ff[1];
                  rsp_c_ff     <= norm_ff[2];
                  rsp_d_ff     <= norm_ff[3];
                  rsp_degen_ff <= degen_ff;
                  rsp_last_ff  <= (plane_ff == fpe_pkg::PLANE_FAR);
                  if (plane_ff == fpe_pkg::PLANE_FAR) begin
                     state_ff <= S_IDLE;
                  end else begin
                     plane_ff <= plane_ff + 3'd1;
                     ci_ff    <= '0;
                     state_ff <= S_PRD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_plane_index = rsp_index_ff;
   assign rsp_plane_a     = rsp_a_ff;
   assign rsp_plane_b     = rsp_b_ff;
   assign rsp_plane_c     = rsp_c_ff;
   assign rsp_plane_d     = rsp_d_ff;
   assign rsp_degenerate  = rsp_degen_ff;
   assign rsp_last_plane  = rsp_last_ff;

endmodule

// File: src/fpe_ram.sv
// ----------------------------------------------------------------------------
// fpe_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module fpe_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
